FILE: design/lpm_pkg.sv
`timescale 1ns / 1ps
package lpm_pkg;

    localparam int ROUTES_DEF = 64;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_DEL    = 2'd2;
    localparam logic [1:0] OP_VIA    = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADLEN   = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_UNREACH  = 3'd4;

    localparam logic [5:0] MAX_LEN = 6'd32;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic [31:0] gateway;
        logic [7:0]  device_id;
        logic        is_connected;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic        hit;
        logic [31:0] out_gateway;
        logic [7:0]  out_device;
        logic        out_connected;
        logic [5:0]  match_len;
        logic [31:0] match_prefix;
    } t_rsp;

    // front-to-back request: original fields plus decoded mask and length check
    typedef struct packed {
        t_req        req;
        logic [31:0] mask;
        logic        len_bad;
    } t_cmd;

    // mask for a length 0..32; longer lengths give all ones (not used then)
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0) begin
            m = 32'h0;
        end else if (len >= MAX_LEN) begin
            m = 32'hffff_ffff;
        end else begin
            m = 32'hffff_ffff << (6'd32 - len);
        end
        return m;
    endfunction

endpackage

FILE: design/lpm_front.sv
`timescale 1ns / 1ps
module lpm_front
    import lpm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_cmd_valid,
    input  logic i_cmd_stall,
    output t_cmd o_cmd
);

    logic r_valid;
    t_cmd r_cmd;

    assign o_stall     = r_valid & i_cmd_stall;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // decode register: precompute mask and length check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_cmd.req     <= i_req;
            r_cmd.mask    <= len_mask(i_req.prefix_len);
            r_cmd.len_bad <= (i_req.prefix_len > MAX_LEN);
        end
    end

endmodule

FILE: design/lpm_fifo.sv
`timescale 1ns / 1ps
module lpm_fifo
    import lpm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_cmd i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_data
);

    // two-entry queue
    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid & ~o_stall;
    assign w_pop   = o_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_data;
    end

endmodule

FILE: design/lpm_back.sv
`timescale 1ns / 1ps
module lpm_back
    import lpm_pkg::*;
#(
    parameter int ROUTES = ROUTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    localparam int AW = $clog2(ROUTES);
    localparam logic [AW:0] LAST = (AW+1)'(ROUTES - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_SCAN2 = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  len;
        logic [31:0] gateway;
        logic [7:0]  device;
        logic        connected;
    } t_ent;

    t_ent         r_mem [ROUTES];
    logic [ROUTES-1:0] r_slot_valid;
    t_ent         r_rd;
    logic         r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic         r_rd_live;

    logic [2:0]   r_state;
    t_cmd         r_cmd;
    logic [AW:0]  r_addr;
    logic         r_pass2;     // add-via second scan in progress
    logic [31:0]  r_key;       // lookup key or masked prefix
    logic [31:0]  r_prefix;
    logic [7:0]   r_dev;
    logic         r_conn;
    // longest-match tracking
    logic         r_bfound;
    t_ent         r_best;
    // exact match / free slot
    logic         r_efound;
    logic [AW-1:0] r_eidx;
    logic         r_ffound;
    logic [AW-1:0] r_fidx;
    logic         r_out_v;
    t_rsp         r_rsp;

    logic         w_is_lkp;
    logic         w_m_long;
    logic         w_m_exact;
    t_rsp         n_rsp;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_v;
    assign o_rsp   = r_rsp;

    // lookup-style scan when op is lookup, or first pass of add-via
    assign w_is_lkp = (r_cmd.req.op == OP_LOOKUP) || (r_cmd.req.op == OP_VIA && !r_pass2);
    assign w_m_long  = r_rd_vld && ((r_key & len_mask(r_rd.len)) == r_rd.prefix);
    assign w_m_exact = r_rd_vld && (r_rd.len == r_cmd.req.prefix_len)
                       && (r_rd.prefix == r_key);

    // response for the finished scan
    always_comb begin
        n_rsp = '0;
        case (r_cmd.req.op)
            OP_LOOKUP: begin
                if (r_bfound) begin
                    n_rsp.status        = ST_OK;
                    n_rsp.hit           = 1'b1;
                    n_rsp.out_gateway   = r_best.gateway;
                    n_rsp.out_device    = r_best.device;
                    n_rsp.out_connected = r_best.connected;
                    n_rsp.match_len     = r_best.len;
                    n_rsp.match_prefix  = r_best.prefix;
                end else begin
                    n_rsp.status = ST_NOTFOUND;
                end
            end
            OP_DEL: begin
                if (r_cmd.len_bad) n_rsp.status = ST_BADLEN;
                else if (!r_efound) n_rsp.status = ST_NOTFOUND;
            end
            default: begin
                if (r_cmd.req.op == OP_VIA && (!r_bfound || !r_best.connected))
                    n_rsp.status = ST_UNREACH;
                else if (r_cmd.len_bad) n_rsp.status = ST_BADLEN;
                else if (!r_efound && !r_ffound) n_rsp.status = ST_FULL;
            end
        endcase
    end

    // table memory with registered read
    always_ff @(posedge i_clk) begin
        r_rd     <= r_mem[r_addr[AW-1:0]];
        r_rd_vld <= r_slot_valid[r_addr[AW-1:0]] && (r_state == S_SCAN || r_state == S_SCAN2);
        r_rd_idx <= r_addr[AW-1:0];
        if (r_state == S_WRITE && r_cmd.req.op != OP_DEL && !r_cmd.len_bad
            && (r_efound || r_ffound)) begin
            r_mem[r_efound ? r_eidx : r_fidx] <= '{r_prefix, r_cmd.req.prefix_len,
                r_cmd.req.gateway, r_dev, r_conn};
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_v      <= 1'b0;
            r_slot_valid <= '0;
            r_rd_live    <= 1'b0;
        end else begin
            if (r_out_v && !i_stall && r_state != S_OUT) r_out_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd    <= i_cmd;
                        r_pass2  <= 1'b0;
                        r_key    <= (i_cmd.req.op == OP_LOOKUP) ? i_cmd.req.address
                                  : (i_cmd.req.op == OP_VIA) ? i_cmd.req.gateway
                                  : (i_cmd.req.address & i_cmd.mask);
                        r_prefix <= i_cmd.req.address & i_cmd.mask;
                        r_dev    <= i_cmd.req.device_id;
                        r_conn   <= i_cmd.req.is_connected;
                        r_addr   <= '0;
                        r_bfound <= 1'b0;
                        r_efound <= 1'b0;
                        r_ffound <= 1'b0;
                        r_rd_live <= 1'b0;
                        r_state  <= (i_cmd.len_bad && i_cmd.req.op != OP_LOOKUP
                                     && i_cmd.req.op != OP_VIA) ? S_WRITE : S_SCAN;
                    end
                end
                S_SCAN, S_SCAN2: begin
                    r_rd_live <= (r_addr <= LAST);
                    if (r_addr <= LAST) r_addr <= r_addr + 1'b1;
                    if (r_rd_live) begin
                        if (w_is_lkp) begin
                            if (w_m_long && (!r_bfound || r_rd.len > r_best.len)) begin
                                r_bfound <= 1'b1;
                                r_best   <= r_rd;
                            end
                        end else begin
                            if (w_m_exact && !r_efound) begin
                                r_efound <= 1'b1;
                                r_eidx   <= r_rd_idx;
                            end
                            if (!r_slot_valid[r_rd_idx] && !r_ffound) begin
                                r_ffound <= 1'b1;
                                r_fidx   <= r_rd_idx;
                            end
                        end
                    end
                    if (r_rd_live && r_rd_idx == LAST[AW-1:0]) begin
                        r_state <= (r_cmd.req.op == OP_VIA && !r_pass2) ? S_DEC : S_WRITE;
                    end
                end
                S_DEC: begin
                    // gateway resolved: set up second scan for the route itself
                    if (!r_bfound || !r_best.connected || r_cmd.len_bad) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_pass2   <= 1'b1;
                        r_key     <= r_prefix;
                        r_dev     <= r_best.device;
                        r_conn    <= 1'b0;
                        r_addr    <= '0;
                        r_rd_live <= 1'b0;
                        r_state   <= S_SCAN2;
                    end
                end
                S_WRITE: begin
                    // wait until the previous response has left the output register
                    if (!r_out_v || !i_stall) begin
                        r_rsp <= n_rsp;
                        case (r_cmd.req.op)
                            OP_LOOKUP: begin
                            end
                            OP_DEL: begin
                                if (!r_cmd.len_bad && r_efound) r_slot_valid[r_eidx] <= 1'b0;
                            end
                            default: begin
                                if (n_rsp.status == ST_OK) begin
                                    if (r_efound) r_slot_valid[r_eidx] <= 1'b1;
                                    else r_slot_valid[r_fidx] <= 1'b1;
                                end
                            end
                        endcase
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_v || !i_stall) begin
                        r_out_v <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: design/ipv4_longest_prefix_route_table_top.sv
`timescale 1ns / 1ps
// The back end handles one request at a time, reading one table entry per cycle while it
// scans; lookup, add and delete scan the table once, and add-via scans it twice.
// Bad-length add or delete skips the scan; unreachable add-via scans only once.
// A new request enters the back end only once the last one is done; the queue holds
// decoded requests, and a stalled response holds the back end before its table update.
// Reset (synchronous, active low) clears all route valid bits, queue and handshakes.
module ipv4_longest_prefix_route_table_top
    import lpm_pkg::*;
#(
    parameter int ROUTES = ROUTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    logic w_fv, w_fs, w_qv, w_qs;
    t_cmd w_fc, w_qc;

    lpm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_cmd_valid(w_fv), .i_cmd_stall(w_fs), .o_cmd(w_fc)
    );

    lpm_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_fv), .o_stall(w_fs),
        .i_data(w_fc), .o_valid(w_qv), .i_stall(w_qs), .o_data(w_qc)
    );

    lpm_back #(.ROUTES(ROUTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_stall(w_qs),
        .i_cmd(w_qc), .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp)
    );

endmodule
